// ===== src/tmfa_pkg.sv =====
// Package for the truncated-mantissa float adder.
// Types and constants shared by the pipeline stages; no dependencies.
package tmfa_pkg;
  localparam logic [31:0] QnanWord = 32'hFFC0_0000;
  localparam int unsigned MaxTrunc = 22;

  typedef struct packed {
    logic        special;
    logic [31:0] special_word;
    logic        sign;
    logic [7:0]  exp;
    logic [32:0] mag;
    logic [4:0]  trunc;
  } tmfa_s1_t;

  typedef struct packed {
    logic        special;
    logic [31:0] special_word;
    logic        sign;
    logic [9:0]  exp;
    logic [32:0] norm;
    logic [4:0]  trunc;
  } tmfa_s2_t;
endpackage

// ===== src/truncated_mantissa_float_adder.sv =====
// Approximate binary32 adder with a configurable truncated mantissa; three
// register stages (align/add, normalise, round/pack) plus an output register.
// One item per cycle; all stages stall together on tready.
module truncated_mantissa_float_adder import tmfa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // operand_a [31:0], operand_b [63:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // sum_bits [31:0]
);
  logic [4:0]  trunc_q;
  logic        v1_q, v2_q, v3_q, vo_q, adv;
  tmfa_s1_t    s1_d, s1_q;
  tmfa_s2_t    s2_d, s2_q;
  logic [31:0] s3_d, s3_q, out_q;

  assign adv = !vo_q || m_axis_tready;
  assign s_axis_tready = adv;

  tmfa_align u_align (.operand_a_i(s_axis_tdata[31:0]), .operand_b_i(s_axis_tdata[63:32]),
                      .trunc_i(trunc_q), .res_o(s1_d));
  tmfa_norm  u_norm  (.in_i(s1_q), .res_o(s2_d));
  tmfa_round u_round (.in_i(s2_q), .sum_o(s3_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trunc_q <= '0;
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; vo_q <= 1'b0;
    end else begin
      if (cfg_we_i) trunc_q <= cfg_wdata_i;
      if (adv) begin
        v1_q <= s_axis_tvalid; v2_q <= v1_q; v3_q <= v2_q; vo_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d; s2_q <= s2_d; s3_q <= s3_d; out_q <= s3_q;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !vo_q |=> m_axis_tvalid)
    else $error("item lost in pipeline");
`endif
endmodule

// ===== src/tmfa_align.sv =====
// Stage one: unpack, special cases, order, align with sticky, add or subtract.
// Depends on tmfa_pkg.
module tmfa_align import tmfa_pkg::*; (
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  input  logic [4:0]  trunc_i,
  output tmfa_s1_t    res_o
);
  logic [4:0]  t;
  logic [22:0] keep;
  logic        sa, sb, sl, ss;
  logic [7:0]  ea, eb, xa, xb, xl, xs, d;
  logic [22:0] fa, fb;
  logic [23:0] ma, mb, ml, msm;
  logic [31:0] wl, ws, shifted, lostmask;
  logic        swap, sticky;

  always_comb begin
    t    = (trunc_i > 5'(MaxTrunc)) ? 5'(MaxTrunc) : trunc_i;
    keep = 23'h7F_FFFF << t;
    sa = operand_a_i[31]; sb = operand_b_i[31];
    ea = operand_a_i[30:23]; eb = operand_b_i[30:23];
    fa = operand_a_i[22:0] & keep; fb = operand_b_i[22:0] & keep;
    ma = {ea != 8'd0, fa}; mb = {eb != 8'd0, fb};
    xa = (ea != 8'd0) ? ea : 8'd1; xb = (eb != 8'd0) ? eb : 8'd1;
    swap = (xb > xa) || (xb == xa && mb > ma);
    ml = swap ? mb : ma; msm = swap ? ma : mb;
    xl = swap ? xb : xa; xs = swap ? xa : xb;
    sl = swap ? sb : sa; ss = swap ? sa : sb;
    d  = xl - xs;
    wl = {ml, 8'd0};
    ws = {msm, 8'd0};
    if (d >= 8'd32) begin
      lostmask = 32'hFFFF_FFFF;
      shifted  = 32'd0;
      sticky   = ws != 32'd0;
    end else begin
      lostmask = ~(32'hFFFF_FFFF << d[4:0]);
      shifted  = ws >> d[4:0];
      sticky   = (ws & lostmask) != 32'd0;
    end
    res_o.sign  = sl;
    res_o.exp   = xl;
    res_o.trunc = t;
    res_o.mag   = (sl == ss) ? ({1'b0, wl} + {1'b0, shifted | {31'd0, sticky}})
                             : ({1'b0, wl} - {1'b0, shifted | {31'd0, sticky}});
    res_o.special      = 1'b1;
    res_o.special_word = 32'd0;
    if ((ea == 8'hFF && fa != 23'd0) || (eb == 8'hFF && fb != 23'd0)) begin
      res_o.special_word = QnanWord;
    end else if (ea == 8'hFF) begin
      res_o.special_word = (eb == 8'hFF && sa != sb) ? QnanWord : {sa, 8'hFF, 23'd0};
    end else if (eb == 8'hFF) begin
      res_o.special_word = {sb, 8'hFF, 23'd0};
    end else if (ma == 24'd0 && mb == 24'd0) begin
      res_o.special_word = {sa & sb, 31'd0};
    end else begin
      res_o.special = 1'b0;
    end
  end
endmodule

// ===== src/tmfa_norm.sv =====
// Stage two: normalise the leading one to bit 31, exponent permitting.
// Depends on tmfa_pkg.
module tmfa_norm import tmfa_pkg::*; (
  input  tmfa_s1_t in_i,
  output tmfa_s2_t res_o
);
  logic [5:0]  lz;
  logic [9:0]  e;
  logic [5:0]  sh;
  logic [32:0] m;

  always_comb begin
    lz = 6'd33;
    for (int i = 0; i < 33; i++) begin
      if (in_i.mag[i]) lz = 6'(32 - i);
    end
    sh = '0;
    m = in_i.mag;
    e = {2'b00, in_i.exp};
    res_o = '0;
    res_o.special      = in_i.special;
    res_o.special_word = in_i.special_word;
    res_o.sign         = in_i.sign;
    res_o.trunc        = in_i.trunc;
    if (!in_i.special && m == 33'd0) begin
      res_o.special      = 1'b1;
      res_o.special_word = 32'd0;
    end
    if (m[32]) begin
      m = {1'b0, m[32:2], m[1] | m[0]};
      e = e + 10'd1;
    end else begin
      sh = lz - 6'd1;
      if (10'(sh) > e - 10'd1) sh = 6'(e - 10'd1);
      m = m << sh;
      e = e - 10'(sh);
    end
    res_o.norm = m;
    res_o.exp  = e;
  end
endmodule

// ===== src/tmfa_round.sv =====
// Stage three: round to nearest even at the truncation point and pack.
// Depends on tmfa_pkg.
module tmfa_round import tmfa_pkg::*; (
  input  tmfa_s2_t    in_i,
  output logic [31:0] sum_o
);
  logic [5:0]  k;
  logic [31:0] s, q, rem, half, mask;
  logic [32:0] mant;
  logic [9:0]  e;

  always_comb begin
    s    = in_i.norm[31:0];
    k    = 6'd8 + {1'b0, in_i.trunc};
    q    = s >> k;
    mask = ~(32'hFFFF_FFFF << k);
    rem  = s & mask;
    half = 32'd1 << (k - 6'd1);
    if (rem > half || (rem == half && q[0])) q = q + 32'd1;
    mant = {1'b0, q} << in_i.trunc;
    e    = in_i.exp;
    if (mant[24]) begin
      mant = mant >> 1;
      e    = e + 10'd1;
    end
    if (in_i.special) sum_o = in_i.special_word;
    else if (e >= 10'd255) sum_o = {in_i.sign, 8'hFF, 23'd0};
    else sum_o = {in_i.sign, mant[23] ? e[7:0] : 8'd0, mant[22:0]};
  end
endmodule

// ===== dv/tmfa_checker.sv =====
// Checker for the truncated-mantissa float adder: watches both stream ports,
// predicts each sum from the operands and the truncation count, and compares.
// Depends on nothing but the ports of the block.
module tmfa_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [63:0] s_data_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [31:0] m_data_i,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] QnanWord = 32'hFFC0_0000;

  logic [4:0]  trunc_q;
  logic [31:0] sums_q [64];
  int          wr_q, rd_q;

  function automatic logic [63:0] shr_sticky(logic [63:0] x, int unsigned d);
    logic [63:0] lost;
    if (d == 0) return x;
    if (d >= 40) return {63'd0, x != 0};
    lost = x & ((64'd1 << d) - 1);
    return (x >> d) | {63'd0, lost != 0};
  endfunction

  function automatic logic [31:0] fp_sum(logic [31:0] a, logic [31:0] b, logic [4:0] tc);
    int unsigned t, k, xa_e, xb_e, tmp;
    logic [22:0] keep, fa, fb;
    logic        sa, sb, tb;
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb, tm;
    logic [63:0] xa, xb, sum, q, rem, half;
    logic [31:0] mant;
    int          e, p;
    t = tc > 22 ? 22 : tc;
    keep = 23'h7FFFFF & 23'(~((32'd1 << t) - 1));
    sa = a[31]; sb = b[31];
    ea = a[30:23]; eb = b[30:23];
    fa = a[22:0] & keep; fb = b[22:0] & keep;
    if ((ea == 255 && fa != 0) || (eb == 255 && fb != 0)) return QnanWord;
    if (ea == 255) return (eb == 255 && sa != sb) ? QnanWord : {sa, 8'hFF, 23'd0};
    if (eb == 255) return {sb, 8'hFF, 23'd0};
    ma = {ea != 0, fa}; mb = {eb != 0, fb};
    xa_e = ea != 0 ? ea : 1; xb_e = eb != 0 ? eb : 1;
    if (ma == 0 && mb == 0) return {sa & sb, 31'd0};
    if (xb_e > xa_e || (xb_e == xa_e && mb > ma)) begin
      tm = ma; ma = mb; mb = tm;
      tmp = xa_e; xa_e = xb_e; xb_e = tmp;
      tb = sa; sa = sb; sb = tb;
    end
    xa = {32'd0, ma, 8'd0};
    xb = shr_sticky({32'd0, mb, 8'd0}, xa_e - xb_e);
    sum = (sa == sb) ? xa + xb : xa - xb;
    if (sum == 0) return 32'd0;
    e = xa_e;
    p = 63;
    while (!sum[p]) p--;
    while (p > 31) begin
      sum = (sum >> 1) | (sum & 64'd1);
      e++; p--;
    end
    while (p < 31 && e > 1) begin
      sum = sum << 1;
      e--; p++;
    end
    k = 8 + t;
    q = sum >> k;
    rem = sum & ((64'd1 << k) - 1);
    half = 64'd1 << (k - 1);
    if (rem > half || (rem == half && q[0])) q++;
    mant = q[31:0] << t;
    if (mant[31:24] != 0) begin
      mant = mant >> 1;
      e++;
    end
    if (e >= 255) return {sa, 8'hFF, 23'd0};
    return {sa, mant[23] ? e[7:0] : 8'd0, mant[22:0]};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trunc_q <= '0;
      errors_o <= 0;
      wr_q <= 0;
      rd_q <= 0;
    end else begin
      if (cfg_we_i) trunc_q <= cfg_wdata_i;
      if (s_valid_i && s_ready_i) begin
        sums_q[wr_q[5:0]] <= fp_sum(s_data_i[31:0], s_data_i[63:32], trunc_q);
        wr_q <= wr_q + 1;
      end
      if (m_valid_i && m_ready_i) begin
        if (wr_q == rd_q) begin
          $display("%0t: unexpected sum, expected none, actual %h", $time, m_data_i);
          errors_o <= errors_o + 1;
        end else if (sums_q[rd_q[5:0]] !== m_data_i) begin
          $display("%0t: sum mismatch, expected %h, actual %h", $time, sums_q[rd_q[5:0]],
                   m_data_i);
          errors_o <= errors_o + 1;
          rd_q <= rd_q + 1;
        end else begin
          rd_q <= rd_q + 1;
        end
      end
    end
  end

  assign pending_o = wr_q - rd_q;
endmodule

// ===== dv/tb.sv =====
// Testbench top for the truncated-mantissa float adder: drives operand pairs
// and truncation settings with random idling and back-pressure.
// Depends on truncated_mantissa_float_adder and tmfa_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  int          errors, pending, cycles;
  int          send_idle = 0, recv_idle = 0;
  bit          hold_off = 1'b0;

  truncated_mantissa_float_adder dut (.*);

  tmfa_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready), .s_data_i(s_axis_tdata),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .errors_o(errors), .pending_o(pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i)
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle);

  function automatic logic [31:0] rand_float();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(9))
      0: w[30:23] = 8'hFF;
      1: w[30:23] = 8'h00;
      2: w[30:23] = 8'(8'hFE - $urandom_range(3));
      3: w[22:0] = '0;
      4: w[30:23] = 8'(8'd127 + $urandom_range(4) - 2);
      default: ;
    endcase
    return w;
  endfunction

  task automatic send(logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {b, a};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic set_trunc(logic [4:0] v);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic rand_pairs(int n);
    logic [31:0] a, b;
    repeat (n) begin
      a = rand_float();
      b = rand_float();
      case ($urandom_range(4))
        0: b = {~a[31], a[30:0]};
        1: b[30:23] = a[30:23];
        default: ;
      endcase
      send(a, b);
    end
  endtask

  initial begin
    logic [4:0] settings[6];
    settings = '{5'd0, 5'd22, 5'd31, 5'd1, 5'd12, 5'd23};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send(32'h0000_0000, 32'h8000_0000);
    send(32'h8000_0000, 32'h8000_0000);
    send(32'h7F80_0000, 32'hFF80_0000);
    send(32'h7F80_0000, 32'h3F80_0000);
    send(32'h3F80_0000, 32'hFF80_0000);
    send(32'h7FC0_0000, 32'h3F80_0000);
    send(32'h7F80_0001, 32'h0000_0000);
    send(32'h3F80_0000, 32'hBF80_0000);
    send(32'h7F7F_FFFF, 32'h7F7F_FFFF);
    send(32'h0000_0001, 32'h8000_0002);
    send(32'h007F_FFFF, 32'h0000_0001);
    send(32'h3F80_0000, 32'h3380_0000);
    send(32'hFFFF_FFFF, 32'h0000_0000);
    set_trunc(5'd22);
    send(32'h7F80_0001, 32'h3F80_0000);
    send(32'h3FFF_FFFF, 32'h3F80_0000);
    send(32'h7F7F_FFFF, 32'h7F00_0000);
    send(32'h0000_0001, 32'h0040_0000);
    hold_off <= 1'b1;
    fork
      begin repeat (60) @(posedge clk_i); hold_off <= 1'b0; end
      rand_pairs(20);
    join
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 31 : ph == 1 ? 70 : 0;
      recv_idle = ph == 0 ? 70 : ph == 1 ? 31 : 0;
      for (int s = 0; s < 6; s++) begin
        set_trunc(settings[(s + ph) % 6]);
        rand_pairs(100);
      end
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
